/* rtl/core/cpt_pkg.sv */
package cpt_pkg;

  localparam int DIST_WIDTH    = 63;
  localparam int SETUP_STAGES  = 3;
  localparam int SOLVE_STAGES  = 4;
  localparam int PREP_STAGES   = 4;
  localparam int FINISH_STAGES = 3;

  typedef enum logic [1:0] {
    REGION_AB,
    REGION_AC,
    REGION_BC,
    REGION_IN
  } region_t;

endpackage

/* rtl/core/cpt_in_if.sv */
interface cpt_in_if #(parameter int COORD_WIDTH = 24);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] query_x;
  logic signed [COORD_WIDTH-1:0] query_y;
  logic signed [COORD_WIDTH-1:0] query_z;
  logic signed [COORD_WIDTH-1:0] vertex_a_x;
  logic signed [COORD_WIDTH-1:0] vertex_a_y;
  logic signed [COORD_WIDTH-1:0] vertex_a_z;
  logic signed [COORD_WIDTH-1:0] vertex_b_x;
  logic signed [COORD_WIDTH-1:0] vertex_b_y;
  logic signed [COORD_WIDTH-1:0] vertex_b_z;
  logic signed [COORD_WIDTH-1:0] vertex_c_x;
  logic signed [COORD_WIDTH-1:0] vertex_c_y;
  logic signed [COORD_WIDTH-1:0] vertex_c_z;

  modport source (
    output valid, query_x, query_y, query_z,
    output vertex_a_x, vertex_a_y, vertex_a_z,
    output vertex_b_x, vertex_b_y, vertex_b_z,
    output vertex_c_x, vertex_c_y, vertex_c_z,
    input  ready
  );

  modport sink (
    input  valid, query_x, query_y, query_z,
    input  vertex_a_x, vertex_a_y, vertex_a_z,
    input  vertex_b_x, vertex_b_y, vertex_b_z,
    input  vertex_c_x, vertex_c_y, vertex_c_z,
    output ready
  );
endinterface

/* rtl/core/cpt_out_if.sv */
interface cpt_out_if #(parameter int COORD_WIDTH = 24);
  import cpt_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] nearest_x;
  logic signed [COORD_WIDTH-1:0] nearest_y;
  logic signed [COORD_WIDTH-1:0] nearest_z;
  logic [DIST_WIDTH-1:0]         distance_squared;

  modport source (
    output valid, nearest_x, nearest_y, nearest_z, distance_squared,
    input  ready
  );

  modport sink (
    input  valid, nearest_x, nearest_y, nearest_z, distance_squared,
    output ready
  );
endinterface

/* rtl/core/cpt_setup.sv */
module cpt_setup #(parameter int W = 24) (
  input  logic                 clk,
  input  logic                 adv,
  input  logic signed [W-1:0]  qpt [3],
  input  logic signed [W-1:0]  va [3],
  input  logic signed [W-1:0]  vb [3],
  input  logic signed [W-1:0]  vc [3],
  output logic signed [2*W+3:0] a,
  output logic signed [2*W+3:0] b,
  output logic signed [2*W+3:0] c,
  output logic signed [2*W+3:0] d,
  output logic signed [2*W+3:0] e,
  output logic signed [W:0]    e1 [3],
  output logic signed [W:0]    e2 [3],
  output logic signed [W-1:0]  va_o [3],
  output logic signed [W-1:0]  q_o [3]
);
  import cpt_pkg::*;

  localparam int EW = W + 1;
  localparam int PW = 2 * EW;
  localparam int DW = 2 * W + 4;

  logic signed [EW-1:0] e1_1 [3];
  logic signed [EW-1:0] e2_1 [3];
  logic signed [EW-1:0] p_1 [3];
  logic signed [EW-1:0] e1_2 [3];
  logic signed [EW-1:0] e2_2 [3];
  logic signed [PW-1:0] pa [3];
  logic signed [PW-1:0] pb [3];
  logic signed [PW-1:0] pc [3];
  logic signed [PW-1:0] pd [3];
  logic signed [PW-1:0] pe [3];
  logic signed [W-1:0]  va_d [SETUP_STAGES][3];
  logic signed [W-1:0]  q_d [SETUP_STAGES][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        e1_1[k]    <= EW'(vb[k]) - EW'(va[k]);
        e2_1[k]    <= EW'(vc[k]) - EW'(va[k]);
        p_1[k]     <= EW'(va[k]) - EW'(qpt[k]);
        va_d[0][k] <= va[k];
        q_d[0][k]  <= qpt[k];
        for (int s = 1; s < SETUP_STAGES; s++) begin
          va_d[s][k] <= va_d[s-1][k];
          q_d[s][k]  <= q_d[s-1][k];
        end
        pa[k]   <= e1_1[k] * e1_1[k];
        pb[k]   <= e1_1[k] * e2_1[k];
        pc[k]   <= e2_1[k] * e2_1[k];
        pd[k]   <= e1_1[k] * p_1[k];
        pe[k]   <= e2_1[k] * p_1[k];
        e1_2[k] <= e1_1[k];
        e2_2[k] <= e2_1[k];
        e1[k]   <= e1_2[k];
        e2[k]   <= e2_2[k];
      end
      a <= DW'(pa[0]) + DW'(pa[1]) + DW'(pa[2]);
      b <= DW'(pb[0]) + DW'(pb[1]) + DW'(pb[2]);
      c <= DW'(pc[0]) + DW'(pc[1]) + DW'(pc[2]);
      d <= DW'(pd[0]) + DW'(pd[1]) + DW'(pd[2]);
      e <= DW'(pe[0]) + DW'(pe[1]) + DW'(pe[2]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      va_o[k] = va_d[SETUP_STAGES-1][k];
      q_o[k]  = q_d[SETUP_STAGES-1][k];
    end
  end

endmodule

/* rtl/core/cpt_solve.sv */
module cpt_solve #(parameter int W = 24) (
  input  logic                  clk,
  input  logic                  adv,
  input  logic signed [2*W+3:0] a,
  input  logic signed [2*W+3:0] b,
  input  logic signed [2*W+3:0] c,
  input  logic signed [2*W+3:0] d,
  input  logic signed [2*W+3:0] e,
  input  logic signed [W:0]     e1 [3],
  input  logic signed [W:0]     e2 [3],
  input  logic signed [W-1:0]   va [3],
  input  logic signed [W-1:0]   qpt [3],
  output logic [4*W+7:0]        sn,
  output logic [4*W+7:0]        tn,
  output logic [4*W+7:0]        dn,
  output logic signed [W:0]     e1_o [3],
  output logic signed [W:0]     e2_o [3],
  output logic signed [W-1:0]   va_o [3],
  output logic signed [W-1:0]   q_o [3]
);
  import cpt_pkg::*;

  localparam int DW = 2 * W + 4;
  localparam int H  = (DW + 1) / 2;
  localparam int HI = DW - H;
  localparam int RW = 2 * DW + 1;
  localparam int UW = 2 * DW;
  localparam int CW = DW + 2;

  typedef struct packed {
    logic signed [CW-1:0] nd;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ne;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] bcn;
    logic signed [CW-1:0] bcd;
    logic ab_zero;
    logic ab_one;
    logic ac_zero;
    logic ac_one;
    logic bc_zero;
    logic bc_one;
    logic dneg;
    logic bd_lt;
    logic be_lt;
  } side_t;

  logic signed [DW-1:0]     opx [6];
  logic signed [DW-1:0]     opy [6];
  logic signed [2*HI-1:0]   hh [6];
  logic signed [HI+H:0]     hl [6];
  logic signed [HI+H:0]     lh [6];
  logic [2*H-1:0]           ll [6];
  logic signed [RW-1:0]     prod [6];
  logic signed [RW-1:0]     det;
  logic signed [RW-1:0]     s;
  logic signed [RW-1:0]     t;
  side_t                    side_next;
  side_t                    side [3];
  logic signed [W:0]        e1_d [SOLVE_STAGES][3];
  logic signed [W:0]        e2_d [SOLVE_STAGES][3];
  logic signed [W-1:0]      va_d [SOLVE_STAGES][3];
  logic signed [W-1:0]      q_d [SOLVE_STAGES][3];
  logic signed [RW:0]       st_sum;
  logic                     lt;
  region_t                  region;
  logic                     cz;
  logic                     co;
  logic signed [CW-1:0]     cn;
  logic signed [CW-1:0]     cd;
  logic [UW-1:0]            svu;
  logic [UW-1:0]            dvu;
  logic [UW-1:0]            sn_next;
  logic [UW-1:0]            tn_next;
  logic [UW-1:0]            dn_next;

  always_comb begin
    logic signed [CW-1:0] ax, bx, cx, dx, ex;
    opx = '{a, b, b, c, b, a};
    opy = '{c, b, e, d, d, e};
    ax = CW'(a);
    bx = CW'(b);
    cx = CW'(c);
    dx = CW'(d);
    ex = CW'(e);
    side_next.nd      = -dx;
    side_next.ax      = ax;
    side_next.ne      = -ex;
    side_next.cx      = cx;
    side_next.bcn     = cx + ex - bx - dx;
    side_next.bcd     = ax - bx - bx + cx;
    side_next.ab_zero = (-dx) <= 0;
    side_next.ab_one  = ax <= -dx;
    side_next.ac_zero = (-ex) <= 0;
    side_next.ac_one  = cx <= -ex;
    side_next.bc_zero = (cx + ex - bx - dx) <= 0;
    side_next.bc_one  = (ax - bx - bx + cx) <= (cx + ex - bx - dx);
    side_next.dneg    = d < 0;
    side_next.bd_lt   = (bx + dx) < (cx + ex);
    side_next.be_lt   = (bx + ex) < (ax + dx);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        hh[i] <= signed'(opx[i][DW-1:H]) * signed'(opy[i][DW-1:H]);
        hl[i] <= signed'(opx[i][DW-1:H]) * signed'({1'b0, opy[i][H-1:0]});
        lh[i] <= signed'({1'b0, opx[i][H-1:0]}) * signed'(opy[i][DW-1:H]);
        ll[i] <= opx[i][H-1:0] * opy[i][H-1:0];
        prod[i] <= (RW'(hh[i]) <<< (2 * H)) + ((RW'(hl[i]) + RW'(lh[i])) <<< H)
                   + RW'(ll[i]);
      end
      det <= prod[0] - prod[1];
      s   <= prod[2] - prod[3];
      t   <= prod[4] - prod[5];
      side[0] <= side_next;
      side[1] <= side[0];
      side[2] <= side[1];
      sn <= sn_next;
      tn <= tn_next;
      dn <= dn_next;
      for (int k = 0; k < 3; k++) begin
        e1_d[0][k] <= e1[k];
        e2_d[0][k] <= e2[k];
        va_d[0][k] <= va[k];
        q_d[0][k]  <= qpt[k];
        for (int j = 1; j < SOLVE_STAGES; j++) begin
          e1_d[j][k] <= e1_d[j-1][k];
          e2_d[j][k] <= e2_d[j-1][k];
          va_d[j][k] <= va_d[j-1][k];
          q_d[j][k]  <= q_d[j-1][k];
        end
      end
    end
  end

  always_comb begin
    st_sum = (RW+1)'(s) + (RW+1)'(t);
    lt     = st_sum < (RW+1)'(det);
    if (lt) begin
      if (s < 0 && t < 0 && side[2].dneg) begin
        region = REGION_AB;
      end else if (s < 0) begin
        region = REGION_AC;
      end else if (t < 0) begin
        region = REGION_AB;
      end else begin
        region = REGION_IN;
      end
    end else if (s < 0) begin
      region = side[2].bd_lt ? REGION_BC : REGION_AC;
    end else if (t < 0) begin
      region = side[2].be_lt ? REGION_BC : REGION_AB;
    end else begin
      region = REGION_BC;
    end
  end

  always_comb begin
    unique case (region)
      REGION_AB: begin
        cz = side[2].ab_zero;
        co = side[2].ab_one;
        cn = side[2].nd;
        cd = side[2].ax;
      end
      REGION_AC: begin
        cz = side[2].ac_zero;
        co = side[2].ac_one;
        cn = side[2].ne;
        cd = side[2].cx;
      end
      default: begin
        cz = side[2].bc_zero;
        co = side[2].bc_one;
        cn = side[2].bcn;
        cd = side[2].bcd;
      end
    endcase
    if (cz) begin
      svu = '0;
      dvu = UW'(1);
    end else if (co) begin
      svu = UW'(1);
      dvu = UW'(1);
    end else begin
      svu = UW'(unsigned'(cn));
      dvu = UW'(unsigned'(cd));
    end
    unique case (region)
      REGION_AB: begin
        sn_next = svu;
        tn_next = '0;
        dn_next = dvu;
      end
      REGION_AC: begin
        sn_next = '0;
        tn_next = svu;
        dn_next = dvu;
      end
      REGION_BC: begin
        sn_next = svu;
        tn_next = dvu - svu;
        dn_next = dvu;
      end
      default: begin
        sn_next = s[UW-1:0];
        tn_next = t[UW-1:0];
        dn_next = det[UW-1:0];
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1_o[k] = e1_d[SOLVE_STAGES-1][k];
      e2_o[k] = e2_d[SOLVE_STAGES-1][k];
      va_o[k] = va_d[SOLVE_STAGES-1][k];
      q_o[k]  = q_d[SOLVE_STAGES-1][k];
    end
  end

endmodule

/* rtl/core/cpt_div.sv */
module cpt_div #(parameter int W = 24) (
  input  logic                clk,
  input  logic                adv,
  input  logic [4*W+7:0]      sn,
  input  logic [4*W+7:0]      tn,
  input  logic [4*W+7:0]      dn,
  input  logic signed [W:0]   e1,
  input  logic signed [W:0]   e2,
  input  logic signed [W-1:0] va,
  input  logic signed [W-1:0] qpt,
  output logic signed [W+2:0] off,
  output logic signed [W-1:0] va_o,
  output logic signed [W-1:0] q_o
);
  import cpt_pkg::*;

  localparam int EW  = W + 1;
  localparam int UW  = 4 * W + 8;
  localparam int CH  = W + 2;
  localparam int NC  = (UW + CH - 1) / CH;
  localparam int PPW = CH + 1 + EW;
  localparam int NW  = UW + EW + 1;
  localparam int RMW = NW + 1;
  localparam int QB  = W + 2;
  localparam int NST = PREP_STAGES + QB;

  logic [NC*CH-1:0]     snp;
  logic [NC*CH-1:0]     tnp;
  logic signed [PPW-1:0] pp1 [NC];
  logic signed [PPW-1:0] pp2 [NC];
  logic [UW-1:0]        dn_d [3];
  logic signed [NW-1:0] s1;
  logic signed [NW-1:0] s2;
  logic signed [NW-1:0] s1_next;
  logic signed [NW-1:0] s2_next;
  logic signed [NW-1:0] num;
  logic [NW-1:0]        mag;
  logic [RMW-1:0]       rem [QB];
  logic [UW:0]          d2s [QB];
  logic [QB-1:0]        quo [QB+1];
  logic                 negs [QB+1];
  logic [RMW-1:0]       dsh [QB];
  logic                 take [QB];
  logic signed [W-1:0]  va_d [NST];
  logic signed [W-1:0]  q_d [NST];

  assign snp = (NC*CH)'(sn);
  assign tnp = (NC*CH)'(tn);
  assign mag = num[NW-1] ? unsigned'(-num) : unsigned'(num);

  always_comb begin
    s1_next = '0;
    s2_next = '0;
    for (int i = 0; i < NC; i++) begin
      s1_next = s1_next + (NW'(pp1[i]) <<< (i * CH));
      s2_next = s2_next + (NW'(pp2[i]) <<< (i * CH));
    end
  end

  always_comb begin
    for (int j = 0; j < QB; j++) begin
      dsh[j]  = RMW'(d2s[j]) << (QB - 1 - j);
      take[j] = rem[j] >= dsh[j];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NC; i++) begin
        pp1[i] <= signed'({1'b0, snp[i*CH +: CH]}) * e1;
        pp2[i] <= signed'({1'b0, tnp[i*CH +: CH]}) * e2;
      end
      dn_d[0] <= dn;
      dn_d[1] <= dn_d[0];
      dn_d[2] <= dn_d[1];
      s1      <= s1_next;
      s2      <= s2_next;
      num     <= s1 + s2;
      negs[0] <= num[NW-1];
      rem[0]  <= (RMW'(mag) << 1) + RMW'(dn_d[2]);
      d2s[0]  <= {dn_d[2], 1'b0};
      quo[0]  <= '0;
      for (int j = 0; j < QB; j++) begin
        quo[j+1]  <= take[j] ? (quo[j] | (QB'(1) << (QB - 1 - j))) : quo[j];
        negs[j+1] <= negs[j];
      end
      for (int j = 0; j < QB - 1; j++) begin
        rem[j+1] <= take[j] ? rem[j] - dsh[j] : rem[j];
        d2s[j+1] <= d2s[j];
      end
      va_d[0] <= va;
      q_d[0]  <= qpt;
      for (int j = 1; j < NST; j++) begin
        va_d[j] <= va_d[j-1];
        q_d[j]  <= q_d[j-1];
      end
    end
  end

  assign off  = negs[QB] ? -signed'({1'b0, quo[QB]}) : signed'({1'b0, quo[QB]});
  assign va_o = va_d[NST-1];
  assign q_o  = q_d[NST-1];

endmodule

/* rtl/core/cpt_finish.sv */
module cpt_finish #(parameter int W = 24) (
  input  logic                  clk,
  input  logic                  adv,
  input  logic signed [W+2:0]   off [3],
  input  logic signed [W-1:0]   va [3],
  input  logic signed [W-1:0]   qpt [3],
  output logic signed [W-1:0]   near [3],
  output logic [cpt_pkg::DIST_WIDTH-1:0] dsq
);
  import cpt_pkg::*;

  localparam int DFW = W + 5;
  localparam int SQW = 2 * DFW;
  localparam int SMW = SQW + 2;

  logic signed [DFW-1:0] diff [3];
  logic signed [SQW-1:0] sq [3];
  logic signed [W-1:0]   nr1 [3];
  logic signed [W-1:0]   nr2 [3];
  logic signed [SMW-1:0] acc;
  logic [DIST_WIDTH-1:0] dsq_next;

  assign acc = SMW'(sq[0]) + SMW'(sq[1]) + SMW'(sq[2]);

  if (SMW > DIST_WIDTH) begin : g_sat
    assign dsq_next = (|acc[SMW-1:DIST_WIDTH]) ? '1 : acc[DIST_WIDTH-1:0];
  end else begin : g_nosat
    assign dsq_next = DIST_WIDTH'(unsigned'(acc));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        nr1[k]  <= W'(DFW'(va[k]) + DFW'(off[k]));
        diff[k] <= DFW'(va[k]) + DFW'(off[k]) - DFW'(qpt[k]);
        sq[k]   <= diff[k] * diff[k];
        nr2[k]  <= nr1[k];
        near[k] <= nr2[k];
      end
      dsq <= dsq_next;
    end
  end

endmodule

/* rtl/core/closest_point_on_triangle.sv */
// Channel  Side    Beat
// query    sink    query point Q and triangle vertices A, B, C, signed Q8.16
// result   source  nearest point on the triangle, signed Q8.16, and squared distance, unsigned Q31.32
//
// One beat per cycle in and out while the result is not stalled. The restoring
// divider has COORD_WIDTH + 2 stages, one quotient bit each.
// Reset clears the pipeline valid bits and the output skid valid flag.
// A stalled result parks in the skid register; the pipeline then holds.
module closest_point_on_triangle #(
  parameter int COORD_WIDTH = 24
) (
  input  logic             clk,
  input  logic             rst,
  cpt_in_if.sink           query,
  cpt_out_if.source        result
);
  import cpt_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int DW    = 2 * W + 4;
  localparam int UW    = 2 * DW;
  localparam int DEPTH = SETUP_STAGES + SOLVE_STAGES + PREP_STAGES + (W + 2)
                         + FINISH_STAGES;

  logic                  adv;
  logic [DEPTH-1:0]      vld;
  logic                  skid_valid;
  logic signed [W-1:0]   skid_near [3];
  logic [DIST_WIDTH-1:0] skid_dsq;

  logic signed [W-1:0]   qpt [3];
  logic signed [W-1:0]   va [3];
  logic signed [W-1:0]   vb [3];
  logic signed [W-1:0]   vc [3];

  logic signed [DW-1:0]  a, b, c, d, e;
  logic signed [W:0]     e1_s [3];
  logic signed [W:0]     e2_s [3];
  logic signed [W-1:0]   va_s [3];
  logic signed [W-1:0]   q_s [3];
  logic [UW-1:0]         sn, tn, dn;
  logic signed [W:0]     e1_v [3];
  logic signed [W:0]     e2_v [3];
  logic signed [W-1:0]   va_v [3];
  logic signed [W-1:0]   q_v [3];
  logic signed [W+2:0]   off [3];
  logic signed [W-1:0]   va_f [3];
  logic signed [W-1:0]   q_f [3];
  logic signed [W-1:0]   near [3];
  logic [DIST_WIDTH-1:0] dsq;

  always_comb begin
    qpt = '{query.query_x, query.query_y, query.query_z};
    va  = '{query.vertex_a_x, query.vertex_a_y, query.vertex_a_z};
    vb  = '{query.vertex_b_x, query.vertex_b_y, query.vertex_b_z};
    vc  = '{query.vertex_c_x, query.vertex_c_y, query.vertex_c_z};
  end

  assign adv         = !skid_valid;
  assign query.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], query.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      skid_valid <= !result.ready;
    end else begin
      skid_valid <= vld[DEPTH-1] && !result.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      skid_near <= near;
      skid_dsq  <= dsq;
    end
  end

  cpt_setup #(.W(W)) u_setup (
    .clk  (clk),
    .adv  (adv),
    .qpt  (qpt),
    .va   (va),
    .vb   (vb),
    .vc   (vc),
    .a    (a),
    .b    (b),
    .c    (c),
    .d    (d),
    .e    (e),
    .e1   (e1_s),
    .e2   (e2_s),
    .va_o (va_s),
    .q_o  (q_s)
  );

  cpt_solve #(.W(W)) u_solve (
    .clk  (clk),
    .adv  (adv),
    .a    (a),
    .b    (b),
    .c    (c),
    .d    (d),
    .e    (e),
    .e1   (e1_s),
    .e2   (e2_s),
    .va   (va_s),
    .qpt  (q_s),
    .sn   (sn),
    .tn   (tn),
    .dn   (dn),
    .e1_o (e1_v),
    .e2_o (e2_v),
    .va_o (va_v),
    .q_o  (q_v)
  );

  for (genvar k = 0; k < 3; k++) begin : g_axis
    cpt_div #(.W(W)) u_div (
      .clk  (clk),
      .adv  (adv),
      .sn   (sn),
      .tn   (tn),
      .dn   (dn),
      .e1   (e1_v[k]),
      .e2   (e2_v[k]),
      .va   (va_v[k]),
      .qpt  (q_v[k]),
      .off  (off[k]),
      .va_o (va_f[k]),
      .q_o  (q_f[k])
    );
  end

  cpt_finish #(.W(W)) u_finish (
    .clk  (clk),
    .adv  (adv),
    .off  (off),
    .va   (va_f),
    .qpt  (q_f),
    .near (near),
    .dsq  (dsq)
  );

  assign result.valid            = skid_valid || vld[DEPTH-1];
  assign result.nearest_x        = skid_valid ? skid_near[0] : near[0];
  assign result.nearest_y        = skid_valid ? skid_near[1] : near[1];
  assign result.nearest_z        = skid_valid ? skid_near[2] : near[2];
  assign result.distance_squared = skid_valid ? skid_dsq : dsq;

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  a_skid: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !result.ready |=> skid_valid)
    else $error("skid beat dropped before it was taken");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(vld[DEPTH-1] && !result.ready))
    else $error("skid filled without a stalled result");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import cpt_pkg::*;

  localparam int CW       = 24;
  localparam int LATENCY  = CW + 16;
  localparam int N_RANDOM = 1500;
  localparam int QUIET_AT = 1300;
  localparam int PAUSE_AT = 700;
  localparam int U        = 65536;
  localparam int CMAX     = 8388607;
  localparam int CMIN     = -8388608;
  localparam int N_DIR    = 18;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [191:0]  wide_t;

  // order: query, vertex a, vertex b, vertex c; x, y, z within each
  typedef struct {
    coord_t v[12];
  } tri_query_t;

  typedef struct {
    coord_t                nearest_x;
    coord_t                nearest_y;
    coord_t                nearest_z;
    logic [DIST_WIDTH-1:0] distance_squared;
  } nearest_t;

  logic clk;
  logic rst;

  cpt_in_if  #(.COORD_WIDTH(CW)) query_bus ();
  cpt_out_if #(.COORD_WIDTH(CW)) result_bus ();

  closest_point_on_triangle #(.COORD_WIDTH(CW)) dut (
    .clk    (clk),
    .rst    (rst),
    .query  (query_bus),
    .result (result_bus)
  );

  nearest_t nearest_pending[$];
  int       fail_count;
  int       beats_in;
  int       beats_out;
  int       stall_left;
  bit       long_stall_done;
  bit       quiet;

  // directed stimulus: Q, A, B, C
  int dir_coords [N_DIR][12] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{U, 2*U, -U, U, 2*U, -U, 5*U, 0, 0, -3*U, 4*U, U},
    '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX},
    '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN},
    '{U, U, 5*U, 0, 0, 0, 4*U, 0, 0, 0, 4*U, 0},
    '{-U, -U, U, 0, 0, 0, 4*U, 0, 0, 0, 4*U, 0},
    '{6*U, -U, 0, 0, 0, 0, 4*U, 0, 0, 0, 4*U, 0},
    '{-U, 6*U, -U, 0, 0, 0, 4*U, 0, 0, 0, 4*U, 0},
    '{2*U, -3*U, U, 0, 0, 0, 4*U, 0, 0, 0, 4*U, 0},
    '{-3*U, 2*U, 0, 0, 0, 0, 4*U, 0, 0, 0, 4*U, 0},
    '{3*U, 3*U, 2*U, 0, 0, 0, 4*U, 0, 0, 0, 4*U, 0},
    '{-2*U, 7*U, 0, 0, 0, 0, 4*U, 0, 0, 0, 4*U, 0},
    '{7*U, -2*U, 0, 0, 0, 0, 4*U, 0, 0, 0, 4*U, 0},
    '{U, 3*U, 0, 0, 0, 0, 2*U, 2*U, 2*U, 4*U, 4*U, 4*U},
    '{3*U, U, -U, U, U, U, U, U, U, 0, 5*U, 0},
    '{1, 1, 0, 0, 0, 0, 3, 0, 0, 0, 3, 0},
    '{-1, -1, -1, CMAX, 0, CMIN, CMIN, CMAX, 0, 0, CMIN, CMAX},
    '{CMAX, CMIN, 0, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX}
  };
  bit    dir_typed [N_DIR] = '{1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
  longint dir_exp  [N_DIR][4] = '{
    '{0, 0, 0, 0},
    '{U, 2*U, -U, 0},
    '{CMAX, CMAX, CMAX, 64'd844424829468675},
    '{CMIN, CMIN, CMIN, 64'd844424829468675},
    '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0},
    '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0},
    '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}
  };

  function automatic void clamp_ratio(input wide_t num, input wide_t den,
                                      output wide_t frac, output wide_t div);
    if (num <= 0) begin
      frac = 0;
      div  = 1;
    end else if (den <= num) begin
      frac = 1;
      div  = 1;
    end else begin
      frac = num;
      div  = den;
    end
  endfunction

  function automatic wide_t dot3(wide_t u[3], wide_t w[3]);
    return u[0] * w[0] + u[1] * w[1] + u[2] * w[2];
  endfunction

  function automatic nearest_t closest_on_triangle(tri_query_t it);
    wide_t    q[3], va[3], e1[3], e2[3], p[3];
    wide_t    a, b, c, d, e, det, s, t, sn, tn, dn, bc_num, bc_den;
    wide_t    num, mag, rq, pt, diff, dsq;
    coord_t   pts[3];
    nearest_t r;
    bit       s_neg, t_neg, neg;
    for (int k = 0; k < 3; k++) begin
      q[k]  = it.v[k];
      va[k] = it.v[3 + k];
      e1[k] = wide_t'(it.v[6 + k]) - va[k];
      e2[k] = wide_t'(it.v[9 + k]) - va[k];
      p[k]  = va[k] - q[k];
    end
    a = dot3(e1, e1);
    b = dot3(e1, e2);
    c = dot3(e2, e2);
    d = dot3(e1, p);
    e = dot3(e2, p);
    det = a * c - b * b;
    s = b * e - c * d;
    t = b * d - a * e;
    bc_den = a - b - b + c;
    bc_num = c + e - b - d;
    s_neg = s < 0;
    t_neg = t < 0;
    tn = 0;
    sn = 0;
    if (s + t < det) begin
      if (s_neg && t_neg && d < 0) begin
        clamp_ratio(-d, a, sn, dn);
      end else if (s_neg) begin
        clamp_ratio(-e, c, tn, dn);
      end else if (t_neg) begin
        clamp_ratio(-d, a, sn, dn);
      end else begin
        sn = s;
        tn = t;
        dn = det;
      end
    end else if (s_neg) begin
      if (b + d < c + e) begin
        clamp_ratio(bc_num, bc_den, sn, dn);
        tn = dn - sn;
      end else begin
        clamp_ratio(-e, c, tn, dn);
      end
    end else if (t_neg) begin
      if (b + e < a + d) begin
        clamp_ratio(bc_num, bc_den, sn, dn);
        tn = dn - sn;
      end else begin
        clamp_ratio(-d, a, sn, dn);
      end
    end else begin
      clamp_ratio(bc_num, bc_den, sn, dn);
      tn = dn - sn;
    end
    dsq = 0;
    for (int k = 0; k < 3; k++) begin
      num  = sn * e1[k] + tn * e2[k];
      neg  = num < 0;
      mag  = neg ? -num : num;
      rq   = (mag + mag + dn) / (dn + dn);
      pt   = va[k] + (neg ? -rq : rq);
      diff = pt - q[k];
      pts[k] = pt[CW-1:0];
      dsq  = dsq + diff * diff;
    end
    r.nearest_x = pts[0];
    r.nearest_y = pts[1];
    r.nearest_z = pts[2];
    r.distance_squared = (dsq >= (wide_t'(1) <<< 63)) ? {DIST_WIDTH{1'b1}}
                                                      : dsq[DIST_WIDTH-1:0];
    return r;
  endfunction

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 5))
      0: return coord_t'(CMAX);
      1: return coord_t'(CMIN);
      2: return '0;
      3: return '1;
      4: return coord_t'($urandom_range(0, 15) - 8);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic tri_query_t random_query();
    tri_query_t it;
    coord_t     base[3];
    int         spread;
    int         shape;
    shape  = $urandom_range(0, 9);
    spread = 1 << $urandom_range(2, 20);
    for (int k = 0; k < 3; k++) base[k] = coord_t'($urandom);
    for (int j = 0; j < 12; j++) begin
      if (shape <= 5) begin
        it.v[j] = base[j % 3] + coord_t'(int'($urandom_range(0, 2 * spread)) - spread);
      end else if (shape <= 7) begin
        it.v[j] = coord_t'($urandom);
      end else begin
        it.v[j] = pick_extreme();
      end
    end
    // collapse or line up vertices
    if (shape == 8 || $urandom_range(0, 19) == 0) begin
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(0, 2))
          0: it.v[6 + k] = it.v[3 + k];
          1: it.v[9 + k] = it.v[6 + k];
          default: it.v[9 + k] = it.v[6 + k] + (it.v[6 + k] - it.v[3 + k]);
        endcase
      end
    end
    return it;
  endfunction

  task automatic offer(tri_query_t it, nearest_t want);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      query_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    query_bus.valid      <= 1'b1;
    query_bus.query_x    <= it.v[0];
    query_bus.query_y    <= it.v[1];
    query_bus.query_z    <= it.v[2];
    query_bus.vertex_a_x <= it.v[3];
    query_bus.vertex_a_y <= it.v[4];
    query_bus.vertex_a_z <= it.v[5];
    query_bus.vertex_b_x <= it.v[6];
    query_bus.vertex_b_y <= it.v[7];
    query_bus.vertex_b_z <= it.v[8];
    query_bus.vertex_c_x <= it.v[9];
    query_bus.vertex_c_y <= it.v[10];
    query_bus.vertex_c_z <= it.v[11];
    do @(posedge clk); while (!query_bus.ready);
    nearest_pending = {nearest_pending, want};
    beats_in++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_bus.ready <= 1'b0;
    end else if (!quiet && !long_stall_done && beats_out >= 300) begin
      long_stall_done = 1'b1;
      stall_left = 400;
      result_bus.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    nearest_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      beats_out++;
      if (nearest_pending.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        want = nearest_pending.pop_front();
        if (result_bus.nearest_x !== want.nearest_x) begin
          $error("nearest_x expected %0d got %0d", want.nearest_x, result_bus.nearest_x);
          fail_count++;
        end
        if (result_bus.nearest_y !== want.nearest_y) begin
          $error("nearest_y expected %0d got %0d", want.nearest_y, result_bus.nearest_y);
          fail_count++;
        end
        if (result_bus.nearest_z !== want.nearest_z) begin
          $error("nearest_z expected %0d got %0d", want.nearest_z, result_bus.nearest_z);
          fail_count++;
        end
        if (result_bus.distance_squared !== want.distance_squared) begin
          $error("distance_squared expected %0d got %0d", want.distance_squared,
                 result_bus.distance_squared);
          fail_count++;
        end
      end
    end
  end

  initial begin
    tri_query_t it;
    nearest_t   want;
    fail_count = 0;
    beats_in = 0;
    beats_out = 0;
    stall_left = 0;
    long_stall_done = 1'b0;
    quiet = 1'b0;
    rst <= 1'b1;
    query_bus.valid <= 1'b0;
    query_bus.query_x <= '0;
    query_bus.query_y <= '0;
    query_bus.query_z <= '0;
    query_bus.vertex_a_x <= '0;
    query_bus.vertex_a_y <= '0;
    query_bus.vertex_a_z <= '0;
    query_bus.vertex_b_x <= '0;
    query_bus.vertex_b_y <= '0;
    query_bus.vertex_b_z <= '0;
    query_bus.vertex_c_x <= '0;
    query_bus.vertex_c_y <= '0;
    query_bus.vertex_c_z <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      for (int j = 0; j < 12; j++) it.v[j] = coord_t'(dir_coords[i][j]);
      if (dir_typed[i]) begin
        want.nearest_x = coord_t'(dir_exp[i][0]);
        want.nearest_y = coord_t'(dir_exp[i][1]);
        want.nearest_z = coord_t'(dir_exp[i][2]);
        want.distance_squared = dir_exp[i][3][DIST_WIDTH-1:0];
      end else begin
        want = closest_on_triangle(it);
      end
      offer(it, want);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == PAUSE_AT) begin
        // drain before going on
        query_bus.valid <= 1'b0;
        while (nearest_pending.size() != 0) @(posedge clk);
      end
      if (i == QUIET_AT) quiet = 1'b1;
      it = random_query();
      offer(it, closest_on_triangle(it));
    end
    query_bus.valid <= 1'b0;

    while (nearest_pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("%0d queries sent, %0d results checked (directed regions, extremes,", beats_in,
             beats_out);
    $display("degenerate triangles, random mixes, long output stall and a full drain)");
    if (fail_count == 0) begin
      $display("** closest_point_on_triangle: PASSED **");
    end else begin
      $display("** closest_point_on_triangle: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** closest_point_on_triangle: FAILED **");
    $finish;
  end

endmodule
